### hw/rtl/nnfs_pkg.sv
// ----------------------------------------------------------------------------
// Nearest-neighbor fit scaler package
// Shared widths, codes and structures of the scaler blocks.
// ----------------------------------------------------------------------------
package nnfs_pkg;

  localparam int unsigned COORD_W    = 12;  // rectangle position and size
  localparam int unsigned SRC_W      = 9;   // source image size
  localparam int unsigned QX_W       = 11;  // query coordinate
  localparam int unsigned PX_W       = 14;  // signed framebuffer coordinate
  localparam int unsigned NUM_W      = 21;  // local coordinate times source size
  localparam int unsigned Q_W        = 9;   // source coordinate
  localparam int unsigned FBA_W      = 20;
  localparam int unsigned PIX_W      = 32;
  localparam int unsigned SIDX_W     = 16;
  localparam int unsigned IDX_W      = 21;  // linear source index
  localparam int unsigned CFG_DATA_W = 12;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned FIFO_DEPTH = 4;

  localparam int unsigned FB_WIDTH_DEF      = 1024;
  localparam int unsigned FB_HEIGHT_DEF     = 1024;
  localparam int unsigned SOURCE_PIXELS_DEF = 65536;

  localparam logic [CFG_IDX_W-1:0] REG_RECT_X   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RECT_Y   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RECT_W   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_RECT_H   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SRC_W    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_SRC_H    = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_FIT_MODE = 3'd6;

  typedef enum logic {
    OP_LOAD  = 1'b0,
    OP_QUERY = 1'b1
  } op_t;

  // Geometry derived from the configuration registers.
  typedef struct packed {
    logic signed [COORD_W-1:0] rect_x;
    logic signed [COORD_W-1:0] rect_y;
    logic [COORD_W-1:0]        draw_w;
    logic [COORD_W-1:0]        draw_h;
    logic [QX_W-1:0]           off_x;
    logic [QX_W-1:0]           off_y;
    logic [SRC_W-1:0]          src_w;
    logic [SRC_W-1:0]          src_h;
    logic                      blank;
  } geom_t;

  // One classified item as it waits between front and back.
  typedef struct packed {
    op_t               op;
    logic              hit;
    logic [FBA_W-1:0]  fb_addr;
    logic [NUM_W-1:0]  num_x;
    logic [NUM_W-1:0]  num_y;
    logic [SIDX_W-1:0] sidx;
    logic [PIX_W-1:0]  pix;
  } entry_t;

endpackage

### hw/rtl/nnfs_cfg.sv
// ----------------------------------------------------------------------------
// Scaler configuration
// Holds the registers and derives the drawn area with a shared bit-serial
// divider after every register write.
// ----------------------------------------------------------------------------
module nnfs_cfg import nnfs_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output geom_t                 geom,
  output logic                  busy
);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_PLAN = 4'b0010,
    ST_DIVH = 4'b0100,
    ST_DIVW = 4'b1000
  } state_t;

  state_t state_r, state_nxt;

  logic signed [COORD_W-1:0] rect_x_r, rect_y_r;
  logic [COORD_W-1:0]        rect_w_r, rect_h_r;
  logic [SRC_W-1:0]          src_w_r, src_h_r;
  logic                      fit_r;
  logic [COORD_W-1:0]        draw_w_r, draw_h_r, draw_w_nxt, draw_h_nxt;

  logic [NUM_W-1:0] dvd_r, dvd_nxt, quo_r, quo_nxt, step_quo;
  logic [SRC_W-1:0] rem_r, rem_nxt, den;
  logic [SRC_W:0]   rem_sh;
  logic             ge;
  logic [4:0]       cnt_r, cnt_nxt;
  logic             last;
  logic             zero_reg;

  assign zero_reg = (rect_w_r == '0) || (rect_h_r == '0) || (src_w_r == '0) ||
                    (src_h_r == '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rect_x_r <= '0;
      rect_y_r <= '0;
      rect_w_r <= '0;
      rect_h_r <= '0;
      src_w_r  <= '0;
      src_h_r  <= '0;
      fit_r    <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_RECT_X:   rect_x_r <= cfg_data;
        REG_RECT_Y:   rect_y_r <= cfg_data;
        REG_RECT_W:   rect_w_r <= cfg_data;
        REG_RECT_H:   rect_h_r <= cfg_data;
        REG_SRC_W:    src_w_r  <= cfg_data[SRC_W-1:0];
        REG_SRC_H:    src_h_r  <= cfg_data[SRC_W-1:0];
        REG_FIT_MODE: fit_r    <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // One restoring step per cycle: the remainder never reaches the divisor.
  assign den      = (state_r == ST_DIVW) ? src_h_r : src_w_r;
  assign rem_sh   = {rem_r, dvd_r[NUM_W-1]};
  assign ge       = rem_sh >= {1'b0, den};
  assign step_quo = {quo_r[NUM_W-2:0], ge};
  assign last     = (cnt_r == 5'(NUM_W - 1));

  always_comb begin
    state_nxt  = state_r;
    dvd_nxt    = dvd_r;
    quo_nxt    = quo_r;
    rem_nxt    = rem_r;
    cnt_nxt    = cnt_r;
    draw_w_nxt = draw_w_r;
    draw_h_nxt = draw_h_r;
    unique case (state_r)
      ST_IDLE: ;
      ST_PLAN: begin
        draw_w_nxt = rect_w_r;
        draw_h_nxt = rect_h_r;
        if (fit_r && !zero_reg) begin
          dvd_nxt   = NUM_W'(rect_w_r) * NUM_W'(src_h_r);
          quo_nxt   = '0;
          rem_nxt   = '0;
          cnt_nxt   = '0;
          state_nxt = ST_DIVH;
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      ST_DIVH, ST_DIVW: begin
        rem_nxt = ge ? SRC_W'(rem_sh - {1'b0, den}) : rem_sh[SRC_W-1:0];
        quo_nxt = step_quo;
        dvd_nxt = {dvd_r[NUM_W-2:0], 1'b0};
        cnt_nxt = cnt_r + 5'd1;
        if (last) begin
          if (state_r == ST_DIVW) begin
            draw_w_nxt = step_quo[COORD_W-1:0];
            state_nxt  = ST_IDLE;
          end else if (step_quo > NUM_W'(rect_h_r)) begin
            draw_h_nxt = rect_h_r;
            dvd_nxt    = NUM_W'(rect_h_r) * NUM_W'(src_w_r);
            quo_nxt    = '0;
            rem_nxt    = '0;
            cnt_nxt    = '0;
            state_nxt  = ST_DIVW;
          end else begin
            draw_h_nxt = step_quo[COORD_W-1:0];
            state_nxt  = ST_IDLE;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
    if (cfg_we) begin
      state_nxt = ST_PLAN;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_PLAN;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    dvd_r    <= dvd_nxt;
    quo_r    <= quo_nxt;
    rem_r    <= rem_nxt;
    cnt_r    <= cnt_nxt;
    draw_w_r <= draw_w_nxt;
    draw_h_r <= draw_h_nxt;
  end

  logic [COORD_W-1:0] gap_w, gap_h;
  assign gap_w = rect_w_r - draw_w_r;
  assign gap_h = rect_h_r - draw_h_r;

  assign geom.rect_x = rect_x_r;
  assign geom.rect_y = rect_y_r;
  assign geom.draw_w = draw_w_r;
  assign geom.draw_h = draw_h_r;
  assign geom.off_x  = gap_w[COORD_W-1:1];
  assign geom.off_y  = gap_h[COORD_W-1:1];
  assign geom.src_w  = src_w_r;
  assign geom.src_h  = src_h_r;
  assign geom.blank  = zero_reg || (draw_w_r == '0) || (draw_h_r == '0);
  assign busy        = (state_r != ST_IDLE);

endmodule

### hw/rtl/nnfs_front.sv
// ----------------------------------------------------------------------------
// Scaler front end
// Classifies each item: bounds checks, framebuffer address and the
// numerators of the source coordinate divisions.
// ----------------------------------------------------------------------------
module nnfs_front import nnfs_pkg::*; #(
  parameter int unsigned FB_WIDTH  = FB_WIDTH_DEF,
  parameter int unsigned FB_HEIGHT = FB_HEIGHT_DEF
) (
  input  logic              in_opcode,
  input  logic [SIDX_W-1:0] in_source_index,
  input  logic [PIX_W-1:0]  in_pixel_in,
  input  logic [QX_W-1:0]   in_dest_x,
  input  logic [QX_W-1:0]   in_dest_y,
  input  geom_t             geom,
  output entry_t            entry
);

  logic [COORD_W-1:0]   lx, ly;
  logic                 in_x, in_y, on_fb;
  logic signed [PX_W-1:0] px, py;
  logic [31:0]          fb_lin;

  assign lx   = {1'b0, in_dest_x} - {1'b0, geom.off_x};
  assign ly   = {1'b0, in_dest_y} - {1'b0, geom.off_y};
  assign in_x = (in_dest_x >= geom.off_x) && (lx < geom.draw_w);
  assign in_y = (in_dest_y >= geom.off_y) && (ly < geom.draw_h);

  assign px = PX_W'(geom.rect_x) + $signed({3'b000, in_dest_x});
  assign py = PX_W'(geom.rect_y) + $signed({3'b000, in_dest_y});
  assign on_fb = !px[PX_W-1] && !py[PX_W-1] &&
                 (px[PX_W-2:0] < (PX_W-1)'(FB_WIDTH)) &&
                 (py[PX_W-2:0] < (PX_W-1)'(FB_HEIGHT));

  assign fb_lin = 32'(py[PX_W-2:0]) * 32'(FB_WIDTH) + 32'(px[PX_W-2:0]);

  assign entry.op      = op_t'(in_opcode);
  assign entry.hit     = (in_opcode == OP_QUERY) && !geom.blank && in_x && in_y && on_fb;
  assign entry.fb_addr = fb_lin[FBA_W-1:0];
  assign entry.num_x   = NUM_W'(lx) * NUM_W'(geom.src_w);
  assign entry.num_y   = NUM_W'(ly) * NUM_W'(geom.src_h);
  assign entry.sidx    = in_source_index;
  assign entry.pix     = in_pixel_in;

endmodule

### hw/rtl/nnfs_fifo.sv
// ----------------------------------------------------------------------------
// Scaler item queue
// Short register queue that decouples the front end from the back end.
// ----------------------------------------------------------------------------
module nnfs_fifo import nnfs_pkg::*; (
  input  logic   clk,
  input  logic   rst_n,
  input  logic   push,
  input  entry_t push_data,
  output logic   full,
  input  logic   pop,
  output logic   empty,
  output entry_t pop_data
);

  localparam int unsigned PTR_W = $clog2(FIFO_DEPTH);

  entry_t           slot_r [FIFO_DEPTH];
  logic [PTR_W-1:0] wr_r, rd_r;
  logic [PTR_W:0]   cnt_r;

  assign full     = (cnt_r == (PTR_W+1)'(FIFO_DEPTH));
  assign empty    = (cnt_r == '0);
  assign pop_data = slot_r[rd_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) begin
        wr_r <= wr_r + 1'b1;
      end
      if (pop) begin
        rd_r <= rd_r + 1'b1;
      end
      cnt_r <= cnt_r + (PTR_W+1)'(push) - (PTR_W+1)'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_r] <= push_data;
    end
  end

endmodule

### hw/rtl/nnfs_back.sv
// ----------------------------------------------------------------------------
// Scaler back end
// Pipelined division to source coordinates, source index, source memory
// access and the result register.
// ----------------------------------------------------------------------------
module nnfs_back import nnfs_pkg::*; #(
  parameter int unsigned SOURCE_PIXELS = SOURCE_PIXELS_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  geom_t            geom,
  input  logic             item_valid,
  input  entry_t           item,
  output logic             item_ready,
  output logic             out_valid,
  input  logic             out_ready,
  output logic             out_write_enable,
  output logic [FBA_W-1:0] out_fb_address,
  output logic [PIX_W-1:0] out_pixel_out
);

  localparam int unsigned AW = $clog2(SOURCE_PIXELS);

  typedef struct packed {
    op_t               op;
    logic              hit;
    logic [FBA_W-1:0]  fb_addr;
    logic [NUM_W-1:0]  rem_x;
    logic [NUM_W-1:0]  rem_y;
    logic [Q_W-1:0]    q_x;
    logic [Q_W-1:0]    q_y;
    logic [SIDX_W-1:0] sidx;
    logic [PIX_W-1:0]  pix;
  } stage_t;

  logic   adv;
  logic   stg_v_r [Q_W+1];
  stage_t stg_r   [Q_W+1];

  // The whole pipe moves together whenever the result register can move.
  assign adv        = !out_valid || out_ready;
  assign item_ready = adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stg_v_r[0] <= 1'b0;
    end else if (adv) begin
      stg_v_r[0] <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      stg_r[0].op      <= item.op;
      stg_r[0].hit     <= item.hit;
      stg_r[0].fb_addr <= item.fb_addr;
      stg_r[0].rem_x   <= item.num_x;
      stg_r[0].rem_y   <= item.num_y;
      stg_r[0].q_x     <= '0;
      stg_r[0].q_y     <= '0;
      stg_r[0].sidx    <= item.sidx;
      stg_r[0].pix     <= item.pix;
    end
  end

  // One quotient bit per stage, most significant first. For a hit the numerator
  // is below draw size times source size, so the quotient fits Q_W bits.
  for (genvar i = 0; i < Q_W; i++) begin : g_div
    localparam int unsigned B = Q_W - 1 - i;
    logic [NUM_W-1:0] dx, dy;
    logic             gx, gy;
    stage_t           nx;

    assign dx = NUM_W'(geom.draw_w) << B;
    assign dy = NUM_W'(geom.draw_h) << B;
    assign gx = stg_r[i].rem_x >= dx;
    assign gy = stg_r[i].rem_y >= dy;

    always_comb begin
      nx        = stg_r[i];
      nx.rem_x  = gx ? stg_r[i].rem_x - dx : stg_r[i].rem_x;
      nx.rem_y  = gy ? stg_r[i].rem_y - dy : stg_r[i].rem_y;
      nx.q_x[B] = gx;
      nx.q_y[B] = gy;
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        stg_v_r[i+1] <= 1'b0;
      end else if (adv) begin
        stg_v_r[i+1] <= stg_v_r[i];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        stg_r[i+1] <= nx;
      end
    end
  end

  // Index stage: linear source address and its capacity check.
  logic              ix_v_r, ix_ok_r, ix_hit_r;
  op_t               ix_op_r;
  logic [IDX_W-1:0]  ix_addr_r, ix_addr_nxt;
  logic [FBA_W-1:0]  ix_fb_r;
  logic [PIX_W-1:0]  ix_pix_r;
  stage_t            last_s;

  assign last_s = stg_r[Q_W];
  assign ix_addr_nxt = (last_s.op == OP_LOAD) ? IDX_W'(last_s.sidx) :
                       IDX_W'(last_s.q_y) * IDX_W'(geom.src_w) + IDX_W'(last_s.q_x);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ix_v_r <= 1'b0;
    end else if (adv) begin
      ix_v_r <= stg_v_r[Q_W];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      ix_op_r   <= last_s.op;
      ix_hit_r  <= last_s.hit;
      ix_addr_r <= ix_addr_nxt;
      ix_ok_r   <= ix_addr_nxt < IDX_W'(SOURCE_PIXELS);
      ix_fb_r   <= last_s.fb_addr;
      ix_pix_r  <= last_s.pix;
    end
  end

  // Source memory: loads write and queries read at the same pipe position,
  // so every access happens in arrival order.
  logic [PIX_W-1:0] mem [SOURCE_PIXELS];
  logic [PIX_W-1:0] rdata_r;
  logic             we_r;
  logic [FBA_W-1:0] fb_r;
  logic             out_v_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      if (ix_v_r && (ix_op_r == OP_LOAD) && ix_ok_r) begin
        mem[ix_addr_r[AW-1:0]] <= ix_pix_r;
      end
      rdata_r <= mem[ix_addr_r[AW-1:0]];
      we_r    <= ix_hit_r && ix_ok_r;
      fb_r    <= (ix_hit_r && ix_ok_r) ? ix_fb_r : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (adv) begin
      out_v_r <= ix_v_r && (ix_op_r == OP_QUERY);
    end
  end

  assign out_valid        = out_v_r;
  assign out_write_enable = we_r;
  assign out_fb_address   = fb_r;
  assign out_pixel_out    = we_r ? rdata_r : '0;

endmodule

### hw/rtl/nearest_neighbor_fit_scaler.sv
// A query passes the queue, the input register, 9 divider stages, the index
// stage and the memory read into the result register; loads give no result.
// One item per cycle unless out_ready or in_ready stalls; dividers are pipelined.
// After reset and after every configuration write, in_ready stays low while
// the drawn area is derived, in fit mode by a bit-serial divider.
// Reset is synchronous, active low; the source memory is not cleared.
// ----------------------------------------------------------------------------
// Nearest-neighbor fit scaler
// Loads source pixels and answers destination queries with framebuffer writes.
// ----------------------------------------------------------------------------
module nearest_neighbor_fit_scaler import nnfs_pkg::*; #(
  parameter int unsigned FB_WIDTH      = FB_WIDTH_DEF,
  parameter int unsigned FB_HEIGHT     = FB_HEIGHT_DEF,
  parameter int unsigned SOURCE_PIXELS = SOURCE_PIXELS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic                  in_opcode,
  input  logic [SIDX_W-1:0]     in_source_index,
  input  logic [PIX_W-1:0]      in_pixel_in,
  input  logic [QX_W-1:0]       in_dest_x,
  input  logic [QX_W-1:0]       in_dest_y,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic                  out_write_enable,
  output logic [FBA_W-1:0]      out_fb_address,
  output logic [PIX_W-1:0]      out_pixel_out
);

  geom_t  geom;
  logic   busy, full, empty, item_ready, push;
  entry_t entry, head;

  nnfs_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .geom      (geom),
    .busy      (busy)
  );

  nnfs_front #(
    .FB_WIDTH  (FB_WIDTH),
    .FB_HEIGHT (FB_HEIGHT)
  ) u_front (
    .in_opcode       (in_opcode),
    .in_source_index (in_source_index),
    .in_pixel_in     (in_pixel_in),
    .in_dest_x       (in_dest_x),
    .in_dest_y       (in_dest_y),
    .geom            (geom),
    .entry           (entry)
  );

  assign in_ready = !full && !busy;
  assign push     = in_valid && in_ready;

  nnfs_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (entry),
    .full      (full),
    .pop       (!empty && item_ready),
    .empty     (empty),
    .pop_data  (head)
  );

  nnfs_back #(
    .SOURCE_PIXELS (SOURCE_PIXELS)
  ) u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .geom             (geom),
    .item_valid       (!empty),
    .item             (head),
    .item_ready       (item_ready),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_write_enable (out_write_enable),
    .out_fb_address   (out_fb_address),
    .out_pixel_out    (out_pixel_out)
  );

endmodule

### sim/nearest_neighbor_fit_scaler_test.sv
// ----------------------------------------------------------------------------
// Nearest-neighbor fit scaler testbench
// Loads source pixels and streams destination queries under a series of
// rectangle, source size and fit settings, with random idling on both
// channels. Each result transfer is checked against a given or predicted write.
// ----------------------------------------------------------------------------
module nearest_neighbor_fit_scaler_test import nnfs_pkg::*; ();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned FBW        = 1024;
  localparam int unsigned FBH        = 1024;
  localparam int unsigned CAPACITY   = 65536;
  localparam int unsigned DRAIN_WAIT = 20;
  localparam int unsigned STALL_LIMIT = 5000;
  localparam int unsigned PHASES     = 12;
  localparam int unsigned PHASE_ITEMS = 150;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;

  typedef enum logic [1:0] {ROW_CFG, ROW_LOAD, ROW_QUERY} row_kind_t;

  typedef struct packed {
    logic             we;
    logic [FBA_W-1:0] addr;
    logic [PIX_W-1:0] pix;
  } fb_write_t;

  typedef struct packed {
    row_kind_t         kind;
    logic [SIDX_W-1:0] idx;   // register index for a configuration row
    logic [PIX_W-1:0]  data;
    logic [QX_W-1:0]   dx;
    logic [QX_W-1:0]   dy;
    logic              typed; // expectation given in the row
    fb_write_t         res;
  } stim_row_t;

  localparam fb_write_t NO_WRITE = '0;
  localparam int unsigned NUM_ROWS = 37;

  localparam stim_row_t DIRECTED [NUM_ROWS] = '{
    '{ROW_QUERY, 16'd0, 32'd0, 11'd0, 11'd0, 1'b1, NO_WRITE},
    '{ROW_CFG, 16'(REG_RECT_W), 32'd4, 11'd0, 11'd0, 1'b0, NO_WRITE},
    '{ROW_CFG, 16'(REG_RECT_H), 32'd4, 11'd0, 11'd0, 1'b0, NO_WRITE},
    '{ROW_CFG, 16'(REG_SRC_W), 32'd2, 11'd0, 11'd0, 1'b0, NO_WRITE},
    '{ROW_CFG, 16'(REG_SRC_H), 32'd2, 11'd0, 11'd0, 1'b0, NO_WRITE},
    '{ROW_LOAD, 16'd0, 32'hFFFF_FFFF, 11'd0, 11'd0, 1'b0, NO_WRITE},
    '{ROW_LOAD, 16'd1, 32'h0000_0000, 11'd0, 11'd0, 1'b0, NO_WRITE},
    '{ROW_LOAD, 16'd2, 32'hA5A5_A5A5, 11'd0, 11'd0, 1'b0, NO_WRITE},
    '{ROW_LOAD, 16'd3, 32'h5A5A_5A5A, 11'd0, 11'd0, 1'b0, NO_WRITE},
    '{ROW_LOAD, 16'hFFFF, 32'h1234_5678, 11'd0, 11'd0, 1'b0, NO_WRITE},
    '{ROW_QUERY, 16'd0, 32'd0, 11'd0, 11'd0, 1'b1, '{1'b1, 20'd0, 32'hFFFF_FFFF}},
    '{ROW_QUERY, 16'd0, 32'd0, 11'd3, 11'd3, 1'b1, '{1'b1, 20'd3075, 32'h5A5A_5A5A}},
    '{ROW_QUERY, 16'd0, 32'd0, 11'd1, 11'd2, 1'b1, '{1'b1, 20'd2049, 32'hA5A5_A5A5}},
    '{ROW_QUERY, 16'd0, 32'd0, 11'd4, 11'd0, 1'b1, NO_WRITE},
    '{ROW_QUERY, 16'd0, 32'd0, 11'd2047, 11'd2047, 1'b1, NO_WRITE},
    // Fit into an 8x4 rectangle: a 4x4 drawn area centered two columns in.
    '{ROW_CFG, 16'(REG_FIT_MODE), 32'd1, 11'd0, 11'd0, 1'b0, NO_WRITE},
    '{ROW_CFG, 16'(REG_RECT_W), 32'd8, 11'd0, 11'd0, 1'b0, NO_WRITE},
    '{ROW_QUERY, 16'd0, 32'd0, 11'd1, 11'd0, 1'b1, NO_WRITE},
    '{ROW_QUERY, 16'd0, 32'd0, 11'd2, 11'd0, 1'b1, '{1'b1, 20'd2, 32'hFFFF_FFFF}},
    '{ROW_QUERY, 16'd0, 32'd0, 11'd9, 11'd0, 1'b1, NO_WRITE},
    '{ROW_CFG, 16'(REG_RECT_X), 32'h800, 11'd0, 11'd0, 1'b0, NO_WRITE},
    '{ROW_QUERY, 16'd0, 32'd0, 11'd2, 11'd0, 1'b1, NO_WRITE},
    '{ROW_CFG, 16'(REG_RECT_X), 32'h7FF, 11'd0, 11'd0, 1'b0, NO_WRITE},
    '{ROW_QUERY, 16'd0, 32'd0, 11'd2, 11'd0, 1'b1, NO_WRITE},
    // Stretch again, with the rectangle reaching down to the bottom edge.
    '{ROW_CFG, 16'(REG_RECT_X), 32'h000, 11'd0, 11'd0, 1'b0, NO_WRITE},
    '{ROW_CFG, 16'(REG_RECT_Y), 32'd1020, 11'd0, 11'd0, 1'b0, NO_WRITE},
    '{ROW_CFG, 16'(REG_FIT_MODE), 32'd0, 11'd0, 11'd0, 1'b0, NO_WRITE},
    '{ROW_QUERY, 16'd0, 32'd0, 11'd0, 11'd3, 1'b1,
      '{1'b1, 20'd1047552, 32'hA5A5_A5A5}},
    '{ROW_CFG, 16'(REG_UNUSED), 32'hFFF, 11'd0, 11'd0, 1'b0, NO_WRITE},
    '{ROW_QUERY, 16'd0, 32'd0, 11'd1, 11'd1, 1'b0, NO_WRITE},
    // Largest register values: indices run past the source memory.
    '{ROW_CFG, 16'(REG_RECT_Y), 32'd0, 11'd0, 11'd0, 1'b0, NO_WRITE},
    '{ROW_CFG, 16'(REG_RECT_W), 32'd4095, 11'd0, 11'd0, 1'b0, NO_WRITE},
    '{ROW_CFG, 16'(REG_SRC_W), 32'd511, 11'd0, 11'd0, 1'b0, NO_WRITE},
    '{ROW_CFG, 16'(REG_SRC_H), 32'd511, 11'd0, 11'd0, 1'b0, NO_WRITE},
    '{ROW_QUERY, 16'd0, 32'd0, 11'd1000, 11'd2047, 1'b0, NO_WRITE},
    '{ROW_CFG, 16'(REG_RECT_H), 32'd0, 11'd0, 11'd0, 1'b0, NO_WRITE},
    '{ROW_QUERY, 16'd0, 32'd0, 11'd5, 11'd5, 1'b1, NO_WRITE}
  };

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic                  in_opcode = 1'b0;
  logic [SIDX_W-1:0]     in_source_index = '0;
  logic [PIX_W-1:0]      in_pixel_in = '0;
  logic [QX_W-1:0]       in_dest_x = '0;
  logic [QX_W-1:0]       in_dest_y = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic                  out_write_enable;
  logic [FBA_W-1:0]      out_fb_address;
  logic [PIX_W-1:0]      out_pixel_out;

  // Shadow of the scaler configuration and source memory.
  int                rx, ry;
  int unsigned       rw, rh, sw, sh;
  logic              fit;
  logic [PIX_W-1:0]  src_pix [CAPACITY];
  bit                src_loaded [CAPACITY];

  fb_write_t   pending_writes [$];
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned errors = 0;
  int unsigned quiet_cycles = 0;
  int unsigned n_loads = 0, n_queries = 0, n_hits = 0, n_phases = 0;

  always #2 clk = ~clk;

  nearest_neighbor_fit_scaler u_top (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_opcode        (in_opcode),
    .in_source_index  (in_source_index),
    .in_pixel_in      (in_pixel_in),
    .in_dest_x        (in_dest_x),
    .in_dest_y        (in_dest_y),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_write_enable (out_write_enable),
    .out_fb_address   (out_fb_address),
    .out_pixel_out    (out_pixel_out)
  );

  task automatic report(input string what, input logic [PIX_W-1:0] got,
                        input logic [PIX_W-1:0] want);
    errors++;
    if (errors <= 30)
      $display("%0t mismatch %s: got %h expected %h", $realtime, what, got, want);
  endtask

  function automatic int unsigned nearest(input int unsigned pos, input int unsigned src,
                                          input int unsigned drawn);
    int unsigned s;
    s = pos * src / drawn;
    return (s >= src) ? src - 1 : s;
  endfunction

  // Maps a query point to the framebuffer write it causes; idx is the source
  // entry it reads when it writes.
  function automatic fb_write_t scale_point(input logic [QX_W-1:0] qx,
                                            input logic [QX_W-1:0] qy,
                                            output int unsigned idx);
    fb_write_t   r;
    int unsigned dw, dh, ox, oy, lx, ly;
    int          px, py;
    r = '0;
    idx = 0;
    if (rw == 0 || rh == 0 || sw == 0 || sh == 0) return r;
    dw = rw;
    dh = rh;
    if (fit) begin
      dh = rw * sh / sw;
      if (dh > rh) begin
        dh = rh;
        dw = rh * sw / sh;
      end
    end
    if (dw == 0 || dh == 0) return r;
    ox = (rw - dw) / 2;
    oy = (rh - dh) / 2;
    if (qx < ox || qy < oy) return r;
    lx = qx - ox;
    ly = qy - oy;
    if (lx >= dw || ly >= dh) return r;
    px = rx + int'(qx);
    py = ry + int'(qy);
    if (px < 0 || px >= FBW || py < 0 || py >= FBH) return r;
    idx = nearest(ly, sh, dh) * sw + nearest(lx, sw, dw);
    if (idx >= CAPACITY) return r;
    r.we = 1'b1;
    r.addr = FBA_W'(py * FBW + px);
    r.pix = src_pix[idx];
    return r;
  endfunction

  // Every task below is entered and left on a rising clock edge.
  task automatic transfer_item(input op_t op, input logic [SIDX_W-1:0] sidx,
                               input logic [PIX_W-1:0] pix, input logic [QX_W-1:0] dx,
                               input logic [QX_W-1:0] dy, input logic typed,
                               input fb_write_t given);
    int unsigned gap, idx;
    gap = 0;
    while ($urandom_range(99) < send_idle_pct && gap < 40) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_opcode <= op;
    in_source_index <= sidx;
    in_pixel_in <= pix;
    in_dest_x <= dx;
    in_dest_y <= dy;
    do @(posedge clk); while (!in_ready);
    if (op == OP_LOAD) begin
      src_pix[sidx] = pix;
      src_loaded[sidx] = 1'b1;
      n_loads++;
    end else begin
      pending_writes.push_back(typed ? given : scale_point(dx, dy, idx));
      n_queries++;
    end
  endtask

  // A query that would read an empty source entry loads that entry first.
  task automatic query_point(input logic [QX_W-1:0] dx, input logic [QX_W-1:0] dy,
                             input logic typed, input fb_write_t given);
    fb_write_t   r;
    int unsigned idx;
    r = scale_point(dx, dy, idx);
    if (r.we && !src_loaded[idx])
      transfer_item(OP_LOAD, SIDX_W'(idx), $urandom, '0, '0, 1'b0, NO_WRITE);
    transfer_item(OP_QUERY, SIDX_W'($urandom), $urandom, dx, dy, typed, given);
  endtask

  task automatic drain;
    in_valid <= 1'b0;
    while (pending_writes.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  // Leaves the write enable high; cfg_done lowers it.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] index,
                           input logic [CFG_DATA_W-1:0] value);
    cfg_we <= 1'b1;
    cfg_index <= index;
    cfg_data <= value;
    case (index)
      REG_RECT_X:   rx = int'($signed(value));
      REG_RECT_Y:   ry = int'($signed(value));
      REG_RECT_W:   rw = 32'(value);
      REG_RECT_H:   rh = 32'(value);
      REG_SRC_W:    sw = 32'(value[SRC_W-1:0]);
      REG_SRC_H:    sh = 32'(value[SRC_W-1:0]);
      REG_FIT_MODE: fit = value[0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic cfg_done;
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [CFG_DATA_W-1:0] pick_offset;
    case ($urandom_range(7))
      0: return 12'h800;
      1: return 12'h7FF;
      2: return CFG_DATA_W'($urandom);
      default: return CFG_DATA_W'($urandom_range(60) - 20);
    endcase
  endfunction

  function automatic logic [CFG_DATA_W-1:0] pick_rect_size;
    case ($urandom_range(11))
      0: return 12'd0;
      1: return 12'd2048;
      2: return 12'd4095;
      3: return CFG_DATA_W'($urandom);
      default: return CFG_DATA_W'($urandom_range(40, 1));
    endcase
  endfunction

  function automatic logic [CFG_DATA_W-1:0] pick_src_size;
    case ($urandom_range(11))
      0: return 12'd0;
      1: return 12'd256;
      2: return 12'd511;
      3: return 12'd1;
      default: return CFG_DATA_W'($urandom_range(20, 1));
    endcase
  endfunction

  function automatic logic [QX_W-1:0] pick_coord(input int unsigned size);
    if ($urandom_range(9) == 0) return QX_W'($urandom);
    return QX_W'($urandom_range((size + 3 > 2047) ? 2047 : size + 3));
  endfunction

  // Result channel: checking, ready stalls and the stall watchdog.
  always @(posedge clk) begin
    fb_write_t want;
    if (out_valid && out_ready) begin
      if (pending_writes.size() == 0) begin
        report("unexpected result", PIX_W'(out_fb_address), '0);
      end else begin
        want = pending_writes.pop_front();
        if (out_write_enable !== want.we)
          report("write_enable", PIX_W'(out_write_enable), PIX_W'(want.we));
        if (out_fb_address !== want.addr)
          report("fb_address", PIX_W'(out_fb_address), PIX_W'(want.addr));
        if (out_pixel_out !== want.pix) report("pixel_out", out_pixel_out, want.pix);
        if (want.we) n_hits++;
      end
    end
    if ((out_valid && out_ready) || (in_valid && in_ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
    out_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  initial begin
    int unsigned area, n;
    rx = 0; ry = 0; rw = 0; rh = 0; sw = 0; sh = 0; fit = 1'b0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int i = 0; i < NUM_ROWS; i++) begin
      case (DIRECTED[i].kind)
        ROW_CFG: begin
          drain();
          write_reg(CFG_IDX_W'(DIRECTED[i].idx), CFG_DATA_W'(DIRECTED[i].data));
          cfg_done();
        end
        ROW_LOAD: transfer_item(OP_LOAD, DIRECTED[i].idx, DIRECTED[i].data, '0, '0,
                                1'b0, NO_WRITE);
        default: query_point(DIRECTED[i].dx, DIRECTED[i].dy, DIRECTED[i].typed,
                             DIRECTED[i].res);
      endcase
    end

    for (int p = 0; p < PHASES; p++) begin
      drain();
      write_reg(REG_RECT_X, pick_offset());
      write_reg(REG_RECT_Y, pick_offset());
      write_reg(REG_RECT_W, pick_rect_size());
      write_reg(REG_RECT_H, pick_rect_size());
      write_reg(REG_SRC_W, pick_src_size());
      write_reg(REG_SRC_H, pick_src_size());
      write_reg(REG_FIT_MODE, CFG_DATA_W'($urandom_range(1)));
      cfg_done();
      case (p % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 80; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 80; end
        default: begin send_idle_pct = 28; recv_stall_pct = 28; end
      endcase
      n_phases++;
      area = sw * sh;
      for (n = 0; n < PHASE_ITEMS; n++) begin
        if (n == PHASE_ITEMS / 2) drain();
        if ($urandom_range(9) < 4)
          transfer_item(OP_LOAD,
                        (area != 0 && area <= CAPACITY && $urandom_range(3) != 0) ?
                          SIDX_W'($urandom_range(area - 1)) : SIDX_W'($urandom),
                        $urandom, '0, '0, 1'b0, NO_WRITE);
        else
          query_point(pick_coord(rw), pick_coord(rh), 1'b0, NO_WRITE);
      end
    end

    drain();
    $display("Covered %0d configuration phases, %0d loads and %0d queries (%0d writes).",
             n_phases, n_loads, n_queries, n_hits);
    $display("Mismatches: %0d.", errors);
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

### files.f
hw/rtl/nnfs_pkg.sv
hw/rtl/nnfs_cfg.sv
hw/rtl/nnfs_front.sv
hw/rtl/nnfs_fifo.sv
hw/rtl/nnfs_back.sv
hw/rtl/nearest_neighbor_fit_scaler.sv
sim/nearest_neighbor_fit_scaler_test.sv
